// File: src/fkps_pkg.sv
// Package for the five-point keypoint selector: word types, codes and constants.
`default_nettype none

package fkps_pkg;

  localparam int MODE_BITS     = 2;
  localparam int FIELD_ID_BITS = 10;
  localparam int COORD_BITS    = 16;
  localparam int DIM_BITS      = 12;
  localparam int NUM_SLOTS     = 5;
  localparam int CFG_IDX_BITS  = 4;

  localparam int ID_BITS_DEF   = 10;
  localparam int FRAC_BITS_DEF = 4;

  localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RST  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RST = DIM_BITS'(480);

  // Item modes.
  localparam logic [MODE_BITS-1:0] MODE_OFFER  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

  // Slot indexes.
  localparam int SLOT_CENTER = 0;
  localparam int SLOT_PP     = 1;
  localparam int SLOT_PM     = 2;
  localparam int SLOT_MM     = 3;
  localparam int SLOT_MP     = 4;

  typedef struct packed {
    logic [MODE_BITS-1:0]     mode;
    logic [FIELD_ID_BITS-1:0] feature_id;
    logic [COORD_BITS-1:0]    x_pos;
    logic [COORD_BITS-1:0]    y_pos;
    logic                     has_point;
  } feat_word_t;

  typedef struct packed {
    logic [FIELD_ID_BITS-1:0] center_id;
    logic [FIELD_ID_BITS-1:0] quad_pp_id;
    logic [FIELD_ID_BITS-1:0] quad_pm_id;
    logic [FIELD_ID_BITS-1:0] quad_mm_id;
    logic [FIELD_ID_BITS-1:0] quad_mp_id;
    logic [NUM_SLOTS-1:0]     valid_mask;
    logic                     removed;
  } res_word_t;

  // Width of a coordinate offset: wide enough for the input and for the centre.
  function automatic int offset_width(input int frac_bits);
    int cw;
    begin
      cw = DIM_BITS - 1 + frac_bits;
      return (cw > COORD_BITS) ? cw : COORD_BITS;
    end
  endfunction

endpackage

`default_nettype wire

// File: src/five_point_keypoint_selector_top.sv
// Top level of the five-point keypoint selector: handshakes, word registers and config.
`default_nettype none

// The selector keeps five keypoint slots over a stream of feature words. Slot 0 holds
// the feature closest to the image centre in Chebyshev distance; slots 1 to 4 each
// hold, for one quadrant about the centre, the feature with the largest product of
// its absolute offsets. A word can offer a feature (ignored without a 3D point),
// remove an id from every slot, or clear all slots, and each accepted word yields one
// result word showing the slot contents after it. The block takes one word per clock
// while the result is not stalled: a word is captured in an input register, scored
// against all five slots in the next cycle by parallel offset multipliers, and its
// result lands in the output register when that register can load. The slot update
// happens in the same cycle the result is registered, so the following word already
// sees it. A stalled result holds the output register; the input register keeps
// accepting until it also holds a word, so at most two words are in flight. The image
// size registers are written on their own port, always ready, and should be written
// only while no word is in flight.

module five_point_keypoint_selector_top
  import fkps_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    feat_valid,
  output logic                         feat_stall,
  input  wire feat_word_t              feat,
  output logic                         res_valid,
  input  wire logic                    res_stall,
  output res_word_t                    res,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS-1:0]     cfg_data
);

  localparam int DW = offset_width(FRAC_BITS);

  logic [DW-1:0] cx;
  logic [DW-1:0] cy;

  feat_word_t item;
  logic       item_valid;
  logic       advance;
  logic       fire;
  res_word_t  result;

  // The output register can load when it is empty or its word is leaving now.
  assign advance    = !res_valid || !res_stall;
  assign fire       = item_valid && advance;
  assign feat_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (!feat_stall) begin
        item_valid <= feat_valid;
      end
      if (advance) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feat_valid && !feat_stall) begin
      item <= feat;
    end
    if (fire) begin
      res <= result;
    end
  end

  fkps_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cx        (cx),
    .cy        (cy)
  );

  fkps_core #(
    .ID_BITS   (ID_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .fire   (fire),
    .cx     (cx),
    .cy     (cy),
    .result (result)
  );

endmodule

`default_nettype wire

// File: src/fkps_cfg.sv
// Image size registers and the image centre derived from them.
`default_nettype none

module fkps_cfg
  import fkps_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [DIM_BITS-1:0]      cfg_data,
  output logic [offset_width(FRAC_BITS)-1:0] cx,
  output logic [offset_width(FRAC_BITS)-1:0] cy
);

  localparam int DW = offset_width(FRAC_BITS);

  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to indexes past the register list are dropped.
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // Centre is half the size in whole pixels, moved into fixed point.
  assign cx = DW'(image_width[DIM_BITS-1:1]) << FRAC_BITS;
  assign cy = DW'(image_height[DIM_BITS-1:1]) << FRAC_BITS;

endmodule

`default_nettype wire

// File: src/fkps_core.sv
// Slot storage, scoring of one word against all five slots, and the slot update.
`default_nettype none

module fkps_core
  import fkps_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire feat_word_t               item,
  input  wire logic                     fire,
  input  wire logic [offset_width(FRAC_BITS)-1:0] cx,
  input  wire logic [offset_width(FRAC_BITS)-1:0] cy,
  output res_word_t                     result
);

  localparam int DW = offset_width(FRAC_BITS);
  localparam int PW = 2 * DW;

  logic [NUM_SLOTS-1:0]  slot_valid;
  logic [ID_BITS-1:0]    slot_id [NUM_SLOTS];
  logic [COORD_BITS-1:0] slot_x  [NUM_SLOTS];
  logic [COORD_BITS-1:0] slot_y  [NUM_SLOTS];

  logic [NUM_SLOTS-1:0]  slot_valid_next;
  logic [NUM_SLOTS-1:0]  take;
  logic [NUM_SLOTS-1:0]  id_hit;
  logic [NUM_SLOTS-1:0]  quad_hit;
  logic                  removed;
  logic [ID_BITS-1:0]    id_in;
  logic [ID_BITS-1:0]    id_next [NUM_SLOTS];

  logic [DW-1:0] new_adx;
  logic [DW-1:0] new_ady;
  logic [DW-1:0] new_cheb;
  logic [PW-1:0] new_area;
  logic [DW-1:0] old_adx [NUM_SLOTS];
  logic [DW-1:0] old_ady [NUM_SLOTS];
  logic [DW-1:0] old_cheb;
  logic [PW-1:0] old_area [NUM_SLOTS];
  logic          x_ge;
  logic          y_ge;

  function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign id_in = ID_BITS'(item.feature_id);

  assign new_adx  = abs_diff(DW'(item.x_pos), cx);
  assign new_ady  = abs_diff(DW'(item.y_pos), cy);
  assign new_cheb = (new_adx > new_ady) ? new_adx : new_ady;
  assign new_area = PW'(new_adx) * PW'(new_ady);

  // Stored scores are rebuilt every cycle so a new centre applies at once.
  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_score
    assign old_adx[s]  = abs_diff(DW'(slot_x[s]), cx);
    assign old_ady[s]  = abs_diff(DW'(slot_y[s]), cy);
    assign old_area[s] = PW'(old_adx[s]) * PW'(old_ady[s]);
    assign id_hit[s]   = slot_valid[s] && (slot_id[s] == id_in);
  end

  assign old_cheb = (old_adx[SLOT_CENTER] > old_ady[SLOT_CENTER]) ?
                    old_adx[SLOT_CENTER] : old_ady[SLOT_CENTER];

  assign x_ge = DW'(item.x_pos) >= cx;
  assign y_ge = DW'(item.y_pos) >= cy;

  always_comb begin
    quad_hit              = '0;
    quad_hit[SLOT_PP]     = x_ge && y_ge;
    quad_hit[SLOT_PM]     = x_ge && !y_ge;
    quad_hit[SLOT_MM]     = !x_ge && !y_ge;
    quad_hit[SLOT_MP]     = !x_ge && y_ge;
  end

  always_comb begin
    slot_valid_next = slot_valid;
    take            = '0;
    removed         = 1'b0;
    unique case (item.mode)
      MODE_OFFER: begin
        if (item.has_point) begin
          take[SLOT_CENTER] = !slot_valid[SLOT_CENTER] || (new_cheb < old_cheb);
          for (int q = SLOT_PP; q < NUM_SLOTS; q++) begin
            take[q] = quad_hit[q] && (!slot_valid[q] || (new_area > old_area[q]));
          end
          slot_valid_next = slot_valid | take;
        end
      end
      MODE_REMOVE: begin
        slot_valid_next = slot_valid & ~id_hit;
        removed         = |id_hit;
      end
      MODE_CLEAR: begin
        slot_valid_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      id_next[s] = take[s] ? id_in : slot_id[s];
    end
    result.center_id  = slot_valid_next[SLOT_CENTER] ?
                        FIELD_ID_BITS'(id_next[SLOT_CENTER]) : '0;
    result.quad_pp_id = slot_valid_next[SLOT_PP] ? FIELD_ID_BITS'(id_next[SLOT_PP]) : '0;
    result.quad_pm_id = slot_valid_next[SLOT_PM] ? FIELD_ID_BITS'(id_next[SLOT_PM]) : '0;
    result.quad_mm_id = slot_valid_next[SLOT_MM] ? FIELD_ID_BITS'(id_next[SLOT_MM]) : '0;
    result.quad_mp_id = slot_valid_next[SLOT_MP] ? FIELD_ID_BITS'(id_next[SLOT_MP]) : '0;
    result.valid_mask = slot_valid_next;
    result.removed    = removed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (fire) begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (fire && take[s]) begin
        slot_id[s] <= id_in;
        slot_x[s]  <= item.x_pos;
        slot_y[s]  <= item.y_pos;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/fkps_checker.sv
// Port-level checks for the keypoint selector and the bind that attaches them.
`default_nettype none

module fkps_checker
  import fkps_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       feat_valid,
  input wire logic       feat_stall,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire res_word_t  res
);

  // A result word held back by the receiver stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Input back-pressure only comes from a stalled, full output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    feat_stall |-> res_valid && res_stall)
    else $error("input stalled without output back-pressure");

  // An empty slot reports id zero.
  a_empty_ids: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      (res.valid_mask[SLOT_CENTER] || res.center_id == '0) &&
      (res.valid_mask[SLOT_PP] || res.quad_pp_id == '0) &&
      (res.valid_mask[SLOT_PM] || res.quad_pm_id == '0) &&
      (res.valid_mask[SLOT_MM] || res.quad_mm_id == '0) &&
      (res.valid_mask[SLOT_MP] || res.quad_mp_id == '0))
    else $error("empty slot shows a nonzero id");

  // A successful remove leaves at least one slot empty.
  a_removed_mask: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.removed |-> res.valid_mask != '1)
    else $error("removed flagged with all slots full");

endmodule

bind five_point_keypoint_selector_top fkps_checker u_fkps_checker (.*);

`default_nettype wire
